// ===== sv/lkpc_pkg.sv =====
// package with sizes and operation codes of the keyed page cache
`timescale 1ns / 1ps
package lkpc_pkg;

  localparam int unsigned ENTRIES = 4;
  localparam int unsigned IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned KEY_W   = 32;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned TICK_W  = 32;
  localparam int unsigned ACT_W   = 2;
  localparam int unsigned SLOT_W  = 2;

  localparam int unsigned IN_DATA_W  = 2 * KEY_W + WORD_W;
  localparam int unsigned OUT_DATA_W = ((SLOT_W + WORD_W + 7) / 8) * 8;

  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic [ACT_W-1:0] {
    ACT_LOOKUP     = 2'd0,
    ACT_STORE      = 2'd1,
    ACT_INVALIDATE = 2'd2,
    ACT_CLEAR      = 2'd3
  } action_e;

endpackage

// ===== sv/lru_keyed_page_cache_top.sv =====
// top level of the fully associative lru page cache with a shared compare unit
`timescale 1ns / 1ps
// Fully associative cache of lkpc_pkg::ENTRIES entries keyed by form id and field
// offset, with replacement of the least recently used entry by a 32-bit use stamp.
// One transaction on the slave side carries one operation (tuser: lookup, store,
// invalidate, clear all) and yields one result transaction on the master side.
// A single key compare and stamp compare unit walks the entries one per cycle for
// lookup, store and invalidate, while clear all skips the walk; tready is low while
// an operation runs.
// The result sits in an output register, so a new operation is taken while the
// previous result still waits, and the block stalls only when a second result
// is ready before the first one is taken.
module lru_keyed_page_cache_top
  import lkpc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // form_id [31:0], field_offset [63:32], page_word [95:64]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // action [1:0]
  input  logic [ACT_W-1:0]      s_axis_tuser_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // slot [1:0], payload_out [33:2], zero [39:34]
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  // hit [0]
  output logic                  m_axis_tuser_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

  localparam idx_t LAST_IDX = IDX_W'(ENTRIES - 1);

  state_e             state_q;
  action_e            act_q;
  logic [KEY_W-1:0]   form_q;
  logic [KEY_W-1:0]   off_q;
  logic [WORD_W-1:0]  word_q;
  idx_t               cnt_q;

  logic               found_q;
  idx_t               found_idx_q;
  logic [WORD_W-1:0]  found_pay_q;
  logic               inv_found_q;
  idx_t               inv_idx_q;
  idx_t               best_idx_q;
  logic [TICK_W-1:0]  best_stamp_q;

  logic [ENTRIES-1:0] valid_q;
  logic [TICK_W-1:0]  tick_q;

  logic [KEY_W-1:0]   ent_form_q  [ENTRIES];
  logic [KEY_W-1:0]   ent_off_q   [ENTRIES];
  logic [TICK_W-1:0]  ent_stamp_q [ENTRIES];
  logic [WORD_W-1:0]  ent_pay_q   [ENTRIES];

  logic               m_valid_q;
  logic               m_hit_q;
  logic [SLOT_W-1:0]  m_slot_q;
  logic [WORD_W-1:0]  m_pay_q;

  logic               accept;
  logic               out_free;
  logic               match;
  logic               stamp_lower;
  logic [TICK_W-1:0]  tick_d;
  idx_t               victim;
  idx_t               wr_idx;
  logic               wr_stamp;
  logic               wr_entry;

  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign out_free        = !m_valid_q || m_axis_tready_i;

  // shared compare unit on the entry under the scan counter
  assign match = valid_q[cnt_q] && (ent_form_q[cnt_q] == form_q) &&
                 (ent_off_q[cnt_q] == off_q);
  assign stamp_lower = ent_stamp_q[cnt_q] < best_stamp_q;

  assign victim = inv_found_q ? inv_idx_q : best_idx_q;

  always_comb begin
    tick_d   = tick_q;
    wr_idx   = found_idx_q;
    wr_stamp = 1'b0;
    wr_entry = 1'b0;
    if (state_q == ST_FINISH && out_free) begin
      case (act_q)
        ACT_LOOKUP: begin
          if (found_q) begin
            tick_d   = tick_q + TICK_W'(1);
            wr_stamp = 1'b1;
          end
        end
        ACT_STORE: begin
          tick_d   = tick_q + (found_q ? TICK_W'(2) : TICK_W'(1));
          wr_stamp = 1'b1;
          wr_entry = 1'b1;
          if (!found_q) begin
            wr_idx = victim;
          end
        end
        ACT_CLEAR: begin
          tick_d = '0;
        end
        default: begin
          tick_d = tick_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_stamp) begin
      ent_stamp_q[wr_idx] <= tick_d;
    end
    if (wr_entry) begin
      ent_form_q[wr_idx] <= form_q;
      ent_off_q[wr_idx]  <= off_q;
      ent_pay_q[wr_idx]  <= word_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      valid_q      <= '0;
      tick_q       <= '0;
      m_valid_q    <= 1'b0;
      m_hit_q      <= 1'b0;
      m_slot_q     <= '0;
      m_pay_q      <= '0;
      cnt_q        <= '0;
      act_q        <= ACT_LOOKUP;
      form_q       <= '0;
      off_q        <= '0;
      word_q       <= '0;
      found_q      <= 1'b0;
      found_idx_q  <= '0;
      found_pay_q  <= '0;
      inv_found_q  <= 1'b0;
      inv_idx_q    <= '0;
      best_idx_q   <= '0;
      best_stamp_q <= '0;
    end else begin
      tick_q <= tick_d;
      if (m_axis_tready_i && state_q != ST_FINISH) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            act_q   <= action_e'(s_axis_tuser_i);
            form_q  <= s_axis_tdata_i[KEY_W-1:0];
            off_q   <= s_axis_tdata_i[2*KEY_W-1:KEY_W];
            word_q  <= s_axis_tdata_i[2*KEY_W+WORD_W-1:2*KEY_W];
            cnt_q   <= '0;
            found_q <= 1'b0;
            found_idx_q  <= '0;
            found_pay_q  <= '0;
            inv_found_q  <= 1'b0;
            inv_idx_q    <= '0;
            best_idx_q   <= '0;
            state_q <= (action_e'(s_axis_tuser_i) == ACT_CLEAR) ? ST_FINISH : ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (match && !found_q) begin
            found_q     <= 1'b1;
            found_idx_q <= cnt_q;
            found_pay_q <= ent_pay_q[cnt_q];
          end
          if (match && act_q == ACT_INVALIDATE) begin
            valid_q[cnt_q] <= 1'b0;
          end
          if (!valid_q[cnt_q] && !inv_found_q) begin
            inv_found_q <= 1'b1;
            inv_idx_q   <= cnt_q;
          end
          if (cnt_q == '0 || stamp_lower) begin
            best_idx_q   <= cnt_q;
            best_stamp_q <= ent_stamp_q[cnt_q];
          end
          if (cnt_q == LAST_IDX) begin
            state_q <= ST_FINISH;
          end else begin
            cnt_q <= cnt_q + IDX_W'(1);
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            m_valid_q <= 1'b1;
            case (act_q)
              ACT_STORE: begin
                valid_q[wr_idx] <= 1'b1;
                m_hit_q         <= found_q;
                m_slot_q        <= SLOT_W'(wr_idx);
                m_pay_q         <= word_q;
              end
              ACT_CLEAR: begin
                valid_q  <= '0;
                m_hit_q  <= 1'b0;
                m_slot_q <= '0;
                m_pay_q  <= '0;
              end
              default: begin
                m_hit_q  <= found_q;
                m_slot_q <= found_q ? SLOT_W'(found_idx_q) : '0;
                m_pay_q  <= found_q ? found_pay_q : '0;
              end
            endcase
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tuser_o  = m_hit_q;
  assign m_axis_tdata_o  = OUT_DATA_W'({m_pay_q, m_slot_q});

endmodule

// ===== verif/lkpc_checker.sv =====
// checker that predicts and compares every result of the keyed page cache
`timescale 1ns / 1ps
module lkpc_checker
  import lkpc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic [IN_DATA_W-1:0]  in_data_i,
  input  logic [ACT_W-1:0]      in_user_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic [OUT_DATA_W-1:0] out_data_i,
  input  logic                  out_user_i,
  output int unsigned           pending_o,
  output int unsigned           errors_o
);

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic [WORD_W-1:0] payload;
  } outcome_t;

  logic              line_valid   [ENTRIES];
  logic [KEY_W-1:0]  line_form    [ENTRIES];
  logic [KEY_W-1:0]  line_offset  [ENTRIES];
  logic [TICK_W-1:0] line_stamp   [ENTRIES];
  logic [WORD_W-1:0] line_payload [ENTRIES];
  logic [TICK_W-1:0] use_tick;
  outcome_t          outcome_q [$];

  function automatic outcome_t cache_access(input action_e act, input logic [KEY_W-1:0] fid,
                                            input logic [KEY_W-1:0] off,
                                            input logic [WORD_W-1:0] word);
    outcome_t res;
    int       found;
    int       victim;
    int       i;
    res   = '0;
    found = -1;
    for (i = 0; i < ENTRIES; i++) begin
      if (found < 0 && line_valid[i] && line_form[i] == fid && line_offset[i] == off) begin
        found = i;
      end
    end
    case (act)
      ACT_LOOKUP: begin
        if (found >= 0) begin
          use_tick          = use_tick + TICK_W'(1);
          line_stamp[found] = use_tick;
          res.hit           = 1'b1;
          res.slot          = SLOT_W'(found);
          res.payload       = line_payload[found];
        end
      end
      ACT_STORE: begin
        if (found >= 0) begin
          use_tick = use_tick + TICK_W'(1);
          res.hit  = 1'b1;
          victim   = found;
        end else begin
          victim = -1;
          for (i = 0; i < ENTRIES; i++) begin
            if (victim < 0 && !line_valid[i]) victim = i;
          end
          if (victim < 0) begin
            // oldest stamp wins, ties to the lowest index
            victim = 0;
            for (i = 1; i < ENTRIES; i++) begin
              if (line_stamp[i] < line_stamp[victim]) victim = i;
            end
          end
        end
        use_tick             = use_tick + TICK_W'(1);
        line_valid[victim]   = 1'b1;
        line_form[victim]    = fid;
        line_offset[victim]  = off;
        line_stamp[victim]   = use_tick;
        line_payload[victim] = word;
        res.slot             = SLOT_W'(victim);
        res.payload          = word;
      end
      ACT_INVALIDATE: begin
        for (i = ENTRIES - 1; i >= 0; i--) begin
          if (line_valid[i] && line_form[i] == fid && line_offset[i] == off) begin
            res.hit       = 1'b1;
            res.slot      = SLOT_W'(i);
            res.payload   = line_payload[i];
            line_valid[i] = 1'b0;
          end
        end
      end
      default: begin
        for (i = 0; i < ENTRIES; i++) line_valid[i] = 1'b0;
        use_tick = '0;
      end
    endcase
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t want;
    outcome_t got;
    int       i;
    if (!rst_ni) begin
      for (i = 0; i < ENTRIES; i++) begin
        line_valid[i]   = 1'b0;
        line_form[i]    = '0;
        line_offset[i]  = '0;
        line_stamp[i]   = '0;
        line_payload[i] = '0;
      end
      use_tick = '0;
      outcome_q.delete();
      pending_o = 0;
      errors_o  = 0;
    end else begin
      // result side first: a result leaving now belongs to an older transaction
      if (out_valid_i && out_ready_i) begin
        got.hit     = out_user_i;
        got.slot    = out_data_i[SLOT_W-1:0];
        got.payload = out_data_i[SLOT_W+WORD_W-1:SLOT_W];
        if (outcome_q.size() == 0) begin
          $display("%0t: unexpected result hit=%0b slot=%0d payload=%h",
                   $time, got.hit, got.slot, got.payload);
          errors_o++;
        end else begin
          want = outcome_q.pop_front();
          if (got.hit !== want.hit) begin
            $display("%0t: hit expected %0b actual %0b", $time, want.hit, got.hit);
            errors_o++;
          end
          if (got.slot !== want.slot) begin
            $display("%0t: slot expected %0d actual %0d", $time, want.slot, got.slot);
            errors_o++;
          end
          if (got.payload !== want.payload) begin
            $display("%0t: payload expected %h actual %h", $time, want.payload,
                     got.payload);
            errors_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        outcome_q.push_back(cache_access(action_e'(in_user_i), in_data_i[KEY_W-1:0],
                                         in_data_i[2*KEY_W-1:KEY_W],
                                         in_data_i[2*KEY_W+WORD_W-1:2*KEY_W]));
      end
      pending_o = outcome_q.size();
    end
  end

endmodule

// ===== verif/tb.sv =====
// testbench top that drives the keyed page cache and reports the verdict
`timescale 1ns / 1ps
module tb;
  import lkpc_pkg::*;

  localparam int unsigned RANDOM_OPS  = 1000;
  localparam int unsigned KEY_POOL    = 6;
  localparam int unsigned CYCLE_LIMIT = 300000;

  typedef enum int {RX_OPEN, RX_RANDOM, RX_SPARSE} rx_mode_e;

  logic                  clk;
  logic                  rst_n;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic [ACT_W-1:0]      s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tuser;
  int unsigned           pending;
  int unsigned           errors;
  int unsigned           cycle_count = 0;
  int unsigned           burst_left = 0;
  logic [KEY_W-1:0]      pool_form   [KEY_POOL];
  logic [KEY_W-1:0]      pool_offset [KEY_POOL];

  lru_keyed_page_cache_top DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  lkpc_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (s_tvalid),
    .in_ready_i  (s_tready),
    .in_data_i   (s_tdata),
    .in_user_i   (s_tuser),
    .out_valid_i (m_tvalid),
    .out_ready_i (m_tready),
    .out_data_i  (m_tdata),
    .out_user_i  (m_tuser),
    .pending_o   (pending),
    .errors_o    (errors)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("lru_keyed_page_cache_top verification failed");
    $finish;
  end

  // receiver stall pattern
  initial begin
    rx_mode_e mode;
    int       span;
    m_tready = 1'b0;
    forever begin
      mode = rx_mode_e'($urandom_range(2, 0));
      span = $urandom_range(60, 10);
      repeat (span) begin
        @(negedge clk);
        case (mode)
          RX_OPEN:   m_tready <= 1'b1;
          RX_RANDOM: m_tready <= 1'($urandom_range(1, 0));
          default:   m_tready <= ($urandom_range(7, 0) == 0);
        endcase
      end
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_op(input action_e act, input logic [KEY_W-1:0] fid,
                         input logic [KEY_W-1:0] off, input logic [WORD_W-1:0] word);
    int gap;
    s_tuser  <= act;
    s_tdata  <= {word, off, fid};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(20, 0);
      gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  initial begin
    int      n;
    int      k;
    int      r;
    action_e act;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = ACT_LOOKUP;
    rst_n    = 1'b0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part
    send_op(ACT_CLEAR,      32'h0,        32'h0,        32'hffff_ffff);
    send_op(ACT_LOOKUP,     32'h0,        32'h0,        32'h0);
    send_op(ACT_INVALIDATE, 32'h0,        32'h0,        32'h0);
    send_op(ACT_STORE,      32'h0,        32'h0,        32'h0);
    send_op(ACT_STORE,      32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_op(ACT_STORE,      32'h0,        32'hffff_ffff, 32'ha5a5_a5a5);
    send_op(ACT_STORE,      32'hffff_ffff, 32'h0,        32'h5a5a_5a5a);
    send_op(ACT_LOOKUP,     32'h0,        32'h0,        32'h1234_5678);
    send_op(ACT_STORE,      32'h1,        32'h2,        32'h0bad_cafe);
    send_op(ACT_STORE,      32'h0,        32'hffff_ffff, 32'hdead_beef);
    send_op(ACT_LOOKUP,     32'hffff_ffff, 32'hffff_ffff, 32'h0);
    send_op(ACT_INVALIDATE, 32'hffff_ffff, 32'h0,        32'h0);
    send_op(ACT_STORE,      32'h3,        32'h4,        32'h8000_0001);
    send_op(ACT_LOOKUP,     32'h3,        32'h4,        32'h0);
    send_op(ACT_INVALIDATE, 32'h3,        32'h4,        32'hffff_ffff);
    send_op(ACT_INVALIDATE, 32'h3,        32'h4,        32'h0);
    send_op(ACT_LOOKUP,     32'h1,        32'h2,        32'h0);
    send_op(ACT_CLEAR,      32'hffff_ffff, 32'hffff_ffff, 32'h0);
    send_op(ACT_LOOKUP,     32'h1,        32'h2,        32'h0);
    send_op(ACT_STORE,      32'h1,        32'h2,        32'h7fff_ffff);

    // key pool with keys that share one half
    for (k = 0; k < KEY_POOL; k++) begin
      pool_form[k]   = $urandom;
      pool_offset[k] = $urandom;
    end
    pool_form[1]   = pool_form[0];
    pool_offset[2] = pool_offset[0];

    for (n = 0; n < RANDOM_OPS; n++) begin
      if (n == RANDOM_OPS / 2) begin
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge clk);
        @(negedge clk);
      end
      r   = $urandom_range(99, 0);
      act = (r < 40) ? ACT_LOOKUP : (r < 75) ? ACT_STORE :
            (r < 96) ? ACT_INVALIDATE : ACT_CLEAR;
      if ($urandom_range(9, 0) == 0) begin
        k = $urandom_range(KEY_POOL - 1, 0);
        pool_form[k]   = $urandom;
        pool_offset[k] = $urandom;
      end
      k = $urandom_range(KEY_POOL - 1, 0);
      if ($urandom_range(7, 0) == 0) send_op(act, $urandom, $urandom, $urandom);
      else send_op(act, pool_form[k], pool_offset[k], $urandom);
    end

    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4 * (ENTRIES + 2)) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("lru_keyed_page_cache_top verification clean");
    end else begin
      $display("lru_keyed_page_cache_top verification failed");
    end
    $finish;
  end

endmodule
